### sv/email_address_checker_top_assert.svh
// assertion macros for the email address checker
// used by email_address_checker_top; no other dependencies
`ifndef EMAIL_ADDRESS_CHECKER_TOP_ASSERT_SVH
`define EMAIL_ADDRESS_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EAC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define EAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/eac_pkg.sv
// types, phase codes and byte classification for the email address checker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package eac_pkg;

  localparam int ByteW = 8;

  // parse phase codes
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_LOCAL  = 2'd1;
  localparam logic [1:0] PH_AT     = 2'd2;
  localparam logic [1:0] PH_DOMAIN = 2'd3;

  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_DEL   = 8'h7f;
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2e;
  localparam logic [ByteW-1:0] CH_DASH  = 8'h2d;
  localparam logic [ByteW-1:0] CH_AT    = 8'h40;

  typedef struct packed {
    logic letter;
    logic alnum;
    logic dot;
    logic dot_dash;
    logic at;
    logic domain_bad;
  } byte_class_t;

  typedef struct packed {
    logic [1:0] parse_phase;
    logic       prev_dot_or_dash;
    logic       prev_alnum;
    logic       prev_was_dot;
    logic       domain_dot_seen;
    logic       failed_flag;
  } parse_state_t;

  // verdict handed from the step logic to the result register
  typedef struct packed {
    logic valid;
    logic address_ok;
  } verdict_t;

  localparam parse_state_t STATE_RESET = '{
    parse_phase: PH_FIRST, prev_dot_or_dash: 1'b0, prev_alnum: 1'b0,
    prev_was_dot: 1'b0, domain_dot_seen: 1'b0, failed_flag: 1'b0};

  function automatic logic is_special(input logic [ByteW-1:0] b);
    logic r;
    case (b)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c,
      8'h3b, 8'h3a, 8'h5c, 8'h22, 8'h5b, 8'h5d: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic byte_class_t classify(input logic [ByteW-1:0] b);
    byte_class_t c;
    logic        upper;
    logic        lower;
    logic        digit;
    upper = (b >= 8'h41) && (b <= 8'h5a);
    lower = (b >= 8'h61) && (b <= 8'h7a);
    digit = (b >= 8'h30) && (b <= 8'h39);
    c.letter     = upper | lower;
    c.alnum      = upper | lower | digit;
    c.dot        = (b == CH_DOT);
    c.dot_dash   = (b == CH_DOT) | (b == CH_DASH);
    c.at         = (b == CH_AT);
    c.domain_bad = (b <= CH_SPACE) | (b >= CH_DEL) | is_special(b);
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/eac_step.sv
// parse state registers and the per-byte update rules
// depends on eac_pkg
`timescale 1ns / 1ps
`default_nettype none

module eac_step
  import eac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [ByteW-1:0] data,
  output verdict_t              verdict,
  output parse_state_t          state
);

  parse_state_t state_next;
  byte_class_t  cls;

  assign cls = classify(data);

  // next state for one word
  always_comb begin
    state_next = state;
    verdict.valid = fire && (data == CH_NUL);
    verdict.address_ok = (state.parse_phase == PH_DOMAIN) && !state.failed_flag &&
                         state.domain_dot_seen;
    if (data == CH_NUL) begin
      state_next = STATE_RESET;
    end else if (!state.failed_flag) begin
      case (state.parse_phase)
        PH_FIRST: begin
          if (!cls.letter) state_next.failed_flag = 1'b1;
          state_next.prev_dot_or_dash = 1'b0;
          state_next.prev_alnum = 1'b1;
          state_next.parse_phase = PH_LOCAL;
        end
        PH_LOCAL: begin
          if (cls.at) begin
            if (!state.prev_alnum) state_next.failed_flag = 1'b1;
            state_next.parse_phase = PH_AT;
          end else if (cls.dot_dash) begin
            if (state.prev_dot_or_dash) state_next.failed_flag = 1'b1;
            state_next.prev_dot_or_dash = 1'b1;
            state_next.prev_alnum = 1'b0;
          end else if (cls.alnum) begin
            state_next.prev_dot_or_dash = 1'b0;
            state_next.prev_alnum = 1'b1;
          end else begin
            state_next.failed_flag = 1'b1;
          end
        end
        PH_AT: begin
          if (cls.dot || cls.domain_bad) state_next.failed_flag = 1'b1;
          state_next.prev_was_dot = cls.dot;
          state_next.parse_phase = PH_DOMAIN;
        end
        default: begin
          if (cls.dot) begin
            if (state.prev_was_dot) state_next.failed_flag = 1'b1;
            state_next.domain_dot_seen = 1'b1;
          end
          if (cls.domain_bad) state_next.failed_flag = 1'b1;
          state_next.prev_was_dot = cls.dot;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### sv/eac_out_reg.sv
// result register holding one verdict until the consumer takes it
// depends on eac_pkg
`timescale 1ns / 1ps
`default_nettype none

module eac_out_reg
  import eac_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire verdict_t verdict,
  output logic          room,
  output logic          ok_valid,
  output logic          address_ok,
  input  wire logic     ok_stall
);

  // free when empty or being taken this cycle
  assign room = !ok_valid || !ok_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ok_valid <= 1'b0;
    end else if (verdict.valid) begin
      ok_valid <= 1'b1;
    end else if (!ok_stall) begin
      ok_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (verdict.valid) begin
      address_ok <= verdict.address_ok;
    end
  end

endmodule

`default_nettype wire

### sv/email_address_checker_top.sv
// top level of the email address checker: input register, step logic, result register
// depends on eac_pkg, eac_step, eac_out_reg and email_address_checker_top_assert.svh
//
//   channel   ports                            direction
//   char      char_valid char_stall char_byte  in  (one address byte per word)
//   ok        ok_valid ok_stall address_ok     out (one verdict per zero byte)
//
// one byte per cycle sustained unless a zero byte waits for room in the result register;
// a zero byte passes from the input register straight into the result register as its verdict
// reset clears the parse state and both valid flags; payloads are not reset
// a stalled result register holds back only zero bytes; other bytes keep flowing
// char_stall rises only while a byte waits in the input register
`timescale 1ns / 1ps
`default_nettype none

`include "email_address_checker_top_assert.svh"

module email_address_checker_top
  import eac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             char_valid,
  output logic                  char_stall,
  input  wire logic [ByteW-1:0] char_byte,
  output logic                  ok_valid,
  input  wire logic             ok_stall,
  output logic                  address_ok
);

  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             room;
  logic             fire;
  verdict_t         verdict;
  parse_state_t     state;

  // a held word moves on unless it is a terminator facing a full result register
  assign fire = hold_valid && ((hold_byte != CH_NUL) || room);
  assign char_stall = hold_valid && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!char_stall) begin
      hold_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      hold_byte <= char_byte;
    end
  end

  eac_step u_step (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .data    (hold_byte),
    .verdict (verdict),
    .state   (state)
  );

  eac_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .verdict    (verdict),
    .room       (room),
    .ok_valid   (ok_valid),
    .address_ok (address_ok),
    .ok_stall   (ok_stall)
  );

  // checks
  `EAC_ASSERT_NEXT(a_term_gives_verdict, clk, rst, fire && (hold_byte == CH_NUL), ok_valid, "terminator produced no verdict")
  `EAC_ASSERT_NOW(a_no_overwrite, clk, rst, verdict.valid, !ok_valid || !ok_stall, "verdict overwrote a pending one")
  `EAC_ASSERT_NEXT(a_term_resets_state, clk, rst, verdict.valid, state == STATE_RESET, "state not cleared after terminator")
  `EAC_ASSERT_NOW(a_ok_needs_domain, clk, rst, verdict.valid && verdict.address_ok, state.parse_phase == PH_DOMAIN && state.domain_dot_seen, "accepted address without dotted domain")

endmodule

`default_nettype wire

### verif/tb.sv
// self-checking bench for email_address_checker_top: directed and random byte streams in, verdicts out
// depends on eac_pkg (phase codes, parse state type, byte constants) and the rtl top
`timescale 1ns / 1ps

module tb
  import eac_pkg::*;
();

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             char_valid = 1'b0;
  logic             char_stall;
  logic [ByteW-1:0] char_byte = '0;
  logic             ok_valid;
  logic             ok_stall = 1'b0;
  logic             address_ok;

  // bytes still to be sent and verdicts still owed by the block
  logic [ByteW-1:0] bytes_to_send[$];
  logic             verdicts_due[$];

  // shadow of the parser state
  parse_state_t shadow = STATE_RESET;

  int  errors = 0;
  int  src_gap = 0;
  int  sink_hold = 0;
  bit  src_calm = 1'b0;
  bit  sink_calm = 1'b0;
  bit  verdict_now;
  logic verdict_ok;

  email_address_checker_top DUT (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_byte  (char_byte),
    .ok_valid   (ok_valid),
    .ok_stall   (ok_stall),
    .address_ok (address_ok)
  );

  always #6 clk = ~clk;

  // byte classes
  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_alnum_byte(input logic [7:0] b);
    return is_alpha(b) || (b >= "0" && b <= "9");
  endfunction

  function automatic bit rejected_in_domain(input logic [7:0] b);
    bit hit;
    if (b <= 8'd32 || b >= 8'd127) begin
      hit = 1'b1;
    end else begin
      case (b)
        "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "[", "]": hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

  // advance the shadow parser by one byte; a zero byte yields a verdict
  task automatic parse_byte(input logic [7:0] b, output bit done, output logic ok);
    done = 1'b0;
    ok = 1'b0;
    if (b == CH_NUL) begin
      done = 1'b1;
      ok = (shadow.parse_phase == PH_DOMAIN) && !shadow.failed_flag && shadow.domain_dot_seen;
      shadow = STATE_RESET;
    end else if (!shadow.failed_flag) begin
      case (shadow.parse_phase)
        PH_FIRST: begin
          if (!is_alpha(b)) shadow.failed_flag = 1'b1;
          shadow.prev_dot_or_dash = 1'b0;
          shadow.prev_alnum = 1'b1;
          shadow.parse_phase = PH_LOCAL;
        end
        PH_LOCAL: begin
          if (b == CH_AT) begin
            if (!shadow.prev_alnum) shadow.failed_flag = 1'b1;
            shadow.parse_phase = PH_AT;
          end else if (b == CH_DOT || b == CH_DASH) begin
            if (shadow.prev_dot_or_dash) shadow.failed_flag = 1'b1;
            shadow.prev_dot_or_dash = 1'b1;
            shadow.prev_alnum = 1'b0;
          end else if (is_alnum_byte(b)) begin
            shadow.prev_dot_or_dash = 1'b0;
            shadow.prev_alnum = 1'b1;
          end else begin
            shadow.failed_flag = 1'b1;
          end
        end
        PH_AT: begin
          if (b == CH_DOT || rejected_in_domain(b)) shadow.failed_flag = 1'b1;
          shadow.prev_was_dot = (b == CH_DOT);
          shadow.parse_phase = PH_DOMAIN;
        end
        default: begin
          if (b == CH_DOT) begin
            if (shadow.prev_was_dot) shadow.failed_flag = 1'b1;
            shadow.domain_dot_seen = 1'b1;
          end
          if (rejected_in_domain(b)) shadow.failed_flag = 1'b1;
          shadow.prev_was_dot = (b == CH_DOT);
        end
      endcase
    end
  endtask

  // random content for addresses
  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0: return 8'("A") + 8'($urandom_range(0, 25));
      1: return 8'("a") + 8'($urandom_range(0, 25));
      default: return 8'("0") + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] rand_domain_char();
    case ($urandom_range(0, 9))
      0: return CH_DASH;
      1: return 8'($urandom_range(33, 126));
      default: return rand_alnum();
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) bytes_to_send.push_back(s[i]);
    bytes_to_send.push_back(CH_NUL);
  endtask

  // one address: mostly well formed, some damaged, some pure noise
  task automatic add_address();
    logic [7:0] addr[$];
    int kind;
    int n;
    int pos;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) addr.push_back(8'($urandom_range(1, 255)));
    end else begin
      addr.push_back(8'("a") + 8'($urandom_range(0, 25)) - ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0 && is_alnum_byte(addr[$]))
          addr.push_back($urandom_range(0, 1) ? CH_DOT : CH_DASH);
        else
          addr.push_back(rand_alnum());
      end
      if (!is_alnum_byte(addr[$])) addr.push_back(rand_alnum());
      addr.push_back(CH_AT);
      n = $urandom_range(1, 3);
      for (int l = 0; l < n; l++) begin
        if (l > 0) addr.push_back(CH_DOT);
        repeat ($urandom_range(1, 4)) addr.push_back(rand_domain_char());
      end
      // damage some of them
      if (kind <= 3) begin
        pos = $urandom_range(0, addr.size() - 1);
        case ($urandom_range(0, 3))
          0: addr[pos] = 8'($urandom_range(1, 255));
          1: addr.insert(pos, $urandom_range(0, 1) ? CH_DOT : CH_DASH);
          2: addr.insert(pos, CH_AT);
          default: addr.delete(pos);
        endcase
      end
    end
    foreach (addr[i]) bytes_to_send.push_back(addr[i]);
    bytes_to_send.push_back(CH_NUL);
  endtask

  // driver: present queued bytes with random gaps
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      src_gap <= 0;
    end else if (!(char_valid && char_stall)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        char_valid <= 1'b0;
      end else if (bytes_to_send.size() > 0) begin
        char_byte <= bytes_to_send.pop_front();
        char_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) src_calm = ~src_calm;
        src_gap <= src_calm ? 0 : $urandom_range(0, 8);
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // monitor: check verdicts first, then predict from the accepted byte
  always @(posedge clk) begin
    if (rst) begin
      ok_stall <= 1'b0;
      sink_hold = 0;
    end else begin
      if (ok_valid && !ok_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict, expected none actual %0b", $time, address_ok);
          errors++;
        end else if (address_ok !== verdicts_due[0]) begin
          $display("%0t: address_ok mismatch, expected %0b actual %0b",
                   $time, verdicts_due[0], address_ok);
          errors++;
          void'(verdicts_due.pop_front());
        end else begin
          void'(verdicts_due.pop_front());
        end
        if ($urandom_range(0, 9) == 0) sink_calm = ~sink_calm;
        sink_hold = sink_calm ? 0 : $urandom_range(0, 8);
      end
      if (sink_hold > 0) begin
        ok_stall <= 1'b1;
        sink_hold = sink_hold - 1;
      end else begin
        ok_stall <= 1'b0;
      end
      if (char_valid && !char_stall) begin
        parse_byte(char_byte, verdict_now, verdict_ok);
        if (verdict_now) verdicts_due.push_back(verdict_ok);
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    // empty address, empty domain, no at sign, valid, second at, leading domain dot
    add_text("");
    add_text("a@");
    add_text("Z");
    add_text("z-9@x.y");
    add_text("a@b@");
    add_text("a@.");
    // high byte as first byte
    bytes_to_send.push_back(8'hff);
    bytes_to_send.push_back(CH_NUL);
    while (bytes_to_send.size() < 525) add_address();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (bytes_to_send.size() > 0 || char_valid || verdicts_due.size() > 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("email_address_checker_top regression: pass");
    end else begin
      $display("email_address_checker_top regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("email_address_checker_top regression: fail");
    $finish;
  end

endmodule
